FILE: rtl/core/xpsc_pkg.sv
`default_nettype none

package xpsc_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TBL_AW = 8;
  localparam int unsigned POS_W  = 16;

  // generator words after reset and for a zero seed
  localparam logic [WORD_W-1:0] INIT_W0 = 32'h6C07_8966;
  localparam logic [WORD_W-1:0] INIT_W1 = 32'hDD52_54A5;
  localparam logic [WORD_W-1:0] INIT_W2 = 32'hB952_3B81;
  localparam logic [WORD_W-1:0] INIT_W3 = 32'h03DF_95B3;
  localparam logic [WORD_W-1:0] SEED_MULT = 32'h6C07_8965;

  // odd primes 3 .. 1621; the key uses the low byte
  localparam int unsigned PRIMES [256] = '{
    3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59,
    61, 67, 71, 73, 79, 83, 89, 97, 101, 103, 107, 109, 113, 127, 131, 137,
    139, 149, 151, 157, 163, 167, 173, 179, 181, 191, 193, 197, 199, 211, 223, 227,
    229, 233, 239, 241, 251, 257, 263, 269, 271, 277, 281, 283, 293, 307, 311, 313,
    317, 331, 337, 347, 349, 353, 359, 367, 373, 379, 383, 389, 397, 401, 409, 419,
    421, 431, 433, 439, 443, 449, 457, 461, 463, 467, 479, 487, 491, 499, 503, 509,
    521, 523, 541, 547, 557, 563, 569, 571, 577, 587, 593, 599, 601, 607, 613, 617,
    619, 631, 641, 643, 647, 653, 659, 661, 673, 677, 683, 691, 701, 709, 719, 727,
    733, 739, 743, 751, 757, 761, 769, 773, 787, 797, 809, 811, 821, 823, 827, 829,
    839, 853, 857, 859, 863, 877, 881, 883, 887, 907, 911, 919, 929, 937, 941, 947,
    953, 967, 971, 977, 983, 991, 997, 1009, 1013, 1019, 1021, 1031, 1033, 1039,
    1049, 1051,
    1061, 1063, 1069, 1087, 1091, 1093, 1097, 1103, 1109, 1117, 1123, 1129, 1151,
    1153, 1163, 1171,
    1181, 1187, 1193, 1201, 1213, 1217, 1223, 1229, 1231, 1237, 1249, 1259, 1277,
    1279, 1283, 1289,
    1291, 1297, 1301, 1303, 1307, 1319, 1321, 1327, 1361, 1367, 1373, 1381, 1399,
    1409, 1423, 1427,
    1429, 1433, 1439, 1447, 1451, 1453, 1459, 1471, 1481, 1483, 1487, 1489, 1493,
    1499, 1511, 1523,
    1531, 1543, 1549, 1553, 1559, 1567, 1571, 1579, 1583, 1597, 1601, 1607, 1609,
    1613, 1619, 1621
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED,
    ST_FILL,
    ST_SH_RD1,
    ST_SH_RD2,
    ST_SH_W1,
    ST_SH_W2,
    ST_KEY,
    ST_KEY_WAIT,
    ST_IDX,
    ST_KS_WAIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       seed_step;
    logic [1:0] seed_idx;
    logic       gen;
  } prng_cmd_t;

  typedef struct packed {
    logic              we;
    logic [TBL_AW-1:0] addr;
    logic [BYTE_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic              re;
    logic [TBL_AW-1:0] addr;
  } tbl_rd_t;

endpackage

`default_nettype wire

FILE: rtl/core/xpsc_in_if.sv
`default_nettype none

interface xpsc_in_if;
  logic       valid;
  logic       ready;
  logic       first;
  logic [7:0] data_in;
  logic       last;

  modport source (output valid, output first, output data_in, output last, input ready);
  modport sink (input valid, input first, input data_in, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/xpsc_out_if.sv
`default_nettype none

interface xpsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;
  logic       last_res;

  modport source (output valid, output data_out, output last_res, input ready);
  modport sink (input valid, input data_out, input last_res, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/xpsc_table_ram.sv
`default_nettype none

module xpsc_table_ram (
  input  wire logic                          clk,
  input  wire xpsc_pkg::tbl_wr_t             wr,
  input  wire xpsc_pkg::tbl_rd_t             rd0,
  input  wire xpsc_pkg::tbl_rd_t             rd1,
  output logic [xpsc_pkg::BYTE_W-1:0]        rdata0,
  output logic [xpsc_pkg::BYTE_W-1:0]        rdata1
);

  logic [xpsc_pkg::BYTE_W-1:0] mem [2**xpsc_pkg::TBL_AW];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read data holds until the next read on that port
  always_ff @(posedge clk) begin
    if (rd0.re) begin
      rdata0 <= mem[rd0.addr];
    end
    if (rd1.re) begin
      rdata1 <= mem[rd1.addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/xpsc_prng.sv
`default_nettype none

module xpsc_prng (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [xpsc_pkg::WORD_W-1:0]   key_seed,
  input  wire xpsc_pkg::prng_cmd_t           cmd,
  output logic [xpsc_pkg::WORD_W-1:0]        gen_word
);

  logic [xpsc_pkg::WORD_W-1:0] words [4];
  logic [xpsc_pkg::WORD_W-1:0] seed;
  logic [xpsc_pkg::WORD_W-1:0] gx0;
  logic [xpsc_pkg::WORD_W-1:0] gx1;
  logic [xpsc_pkg::WORD_W-1:0] sx;
  logic [xpsc_pkg::WORD_W-1:0] seed_next;

  // xorshift128 step
  always_comb begin
    gx0      = words[0] ^ (words[0] << 11);
    gx1      = gx0 ^ (gx0 >> 8);
    gen_word = gx1 ^ words[3] ^ (words[3] >> 19);
  end

  // one multiply-add seeding round
  always_comb begin
    sx        = seed ^ (seed >> 30);
    seed_next = sx * xpsc_pkg::SEED_MULT + {{(xpsc_pkg::WORD_W-2){1'b0}}, cmd.seed_idx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      words[0] <= xpsc_pkg::INIT_W0;
      words[1] <= xpsc_pkg::INIT_W1;
      words[2] <= xpsc_pkg::INIT_W2;
      words[3] <= xpsc_pkg::INIT_W3;
    end else if (cmd.load) begin
      words[0] <= xpsc_pkg::INIT_W0;
      words[1] <= xpsc_pkg::INIT_W1;
      words[2] <= xpsc_pkg::INIT_W2;
      words[3] <= xpsc_pkg::INIT_W3;
    end else if (cmd.seed_step) begin
      case (cmd.seed_idx)
        2'd1: words[0] <= seed_next;
        2'd2: words[1] <= seed_next;
        2'd3: words[2] <= seed_next;
        default: ;
      endcase
    end else if (cmd.gen) begin
      words[0] <= words[1];
      words[1] <= words[2];
      words[2] <= words[3];
      words[3] <= gen_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      seed <= key_seed;
    end else if (cmd.seed_step) begin
      seed <= seed_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/xorshift_permutation_stream_cipher_top.sv
// Self-inverse byte cipher. Bytes enter on in_stream (first, data_in, last)
// and leave on out_stream (data_out, last_res), one result word per input
// word, in order. Both channels move a word when valid and ready are high.
// cfg_we/cfg_wdata write the 32-bit key seed; write it only while idle.
// A word with first set rebuilds the 256-entry permutation table held in a
// single-write, dual-read RAM: the word is accepted, 3 seeding rounds run
// when the seed is nonzero, the table is filled with the identity, then
// SHUFFLE_ROUNDS swap rounds run (a round whose two bytes match is dropped).
// The RAM's one write port makes a round's two writes take separate states.
// Per word after the table exists: one keystream table read, or at each
// 256-word block boundary, where the prime key is looked up again, two
// dependent table reads. The result sits in an output register; the next
// word is accepted while it waits, and the engine stalls only when a new
// result is ready and the register is still full.
// Reset (rst, synchronous) clears the seed, position, prime key and
// generator words; the table content is undefined until a first word.
`default_nettype none

module xorshift_permutation_stream_cipher_top #(
  parameter int unsigned SHUFFLE_ROUNDS = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [xpsc_pkg::WORD_W-1:0] cfg_wdata,
  xpsc_in_if.sink                          in_stream,
  xpsc_out_if.source                       out_stream
);

  localparam int unsigned RND_W = $clog2(SHUFFLE_ROUNDS + 1);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(SHUFFLE_ROUNDS - 1);

  xpsc_pkg::state_t state;
  xpsc_pkg::state_t state_next;

  logic [xpsc_pkg::WORD_W-1:0] key_seed;

  // held input word
  logic [xpsc_pkg::BYTE_W-1:0] hold_data;
  logic                        hold_last;

  logic [xpsc_pkg::POS_W-1:0]  position;
  logic [xpsc_pkg::POS_W-1:0]  pos_inc;
  logic [xpsc_pkg::BYTE_W-1:0] prime_key;
  logic [xpsc_pkg::BYTE_W-1:0] ks_idx;

  logic [xpsc_pkg::TBL_AW-1:0] cnt;
  logic [RND_W-1:0]            round_cnt;
  logic [xpsc_pkg::BYTE_W-1:0] swap_a;
  logic [xpsc_pkg::BYTE_W-1:0] swap_b;
  logic [xpsc_pkg::BYTE_W-1:0] swap_ta;

  logic                        out_valid;
  logic [xpsc_pkg::BYTE_W-1:0] out_data;
  logic                        out_last;

  xpsc_pkg::prng_cmd_t         prng_cmd;
  logic [xpsc_pkg::WORD_W-1:0] gen_word;
  xpsc_pkg::tbl_wr_t           tbl_wr;
  xpsc_pkg::tbl_rd_t           tbl_rd0;
  xpsc_pkg::tbl_rd_t           tbl_rd1;
  logic [xpsc_pkg::BYTE_W-1:0] rdata0;
  logic [xpsc_pkg::BYTE_W-1:0] rdata1;

  logic in_take;
  logic out_load;
  logic round_end;

  xpsc_prng u_prng (
    .clk      (clk),
    .rst      (rst),
    .key_seed (key_seed),
    .cmd      (prng_cmd),
    .gen_word (gen_word)
  );

  xpsc_table_ram u_table (
    .clk    (clk),
    .wr     (tbl_wr),
    .rd0    (tbl_rd0),
    .rd1    (tbl_rd1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  assign in_stream.ready     = (state == xpsc_pkg::ST_IDLE);
  assign in_take             = in_stream.valid && in_stream.ready;
  assign out_stream.valid    = out_valid;
  assign out_stream.data_out = out_data;
  assign out_stream.last_res = out_last;

  // keystream index: prime key times (position + 1), low byte only
  assign pos_inc = position + 1'b1;
  assign ks_idx  = xpsc_pkg::BYTE_W'(prime_key * pos_inc[xpsc_pkg::BYTE_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xpsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    prng_cmd   = '0;
    tbl_wr     = '0;
    tbl_rd0    = '0;
    tbl_rd1    = '0;
    out_load   = 1'b0;
    round_end  = 1'b0;
    case (state)
      xpsc_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_stream.first) begin
            prng_cmd.load = 1'b1;
            state_next    = (key_seed != '0) ? xpsc_pkg::ST_SEED : xpsc_pkg::ST_FILL;
          end else begin
            state_next = xpsc_pkg::ST_KEY;
          end
        end
      end
      xpsc_pkg::ST_SEED: begin
        prng_cmd.seed_step = 1'b1;
        prng_cmd.seed_idx  = cnt[1:0];
        if (cnt[1:0] == 2'd3) begin
          state_next = xpsc_pkg::ST_FILL;
        end
      end
      xpsc_pkg::ST_FILL: begin
        // write identity, one entry a cycle
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = cnt;
        tbl_wr.data = cnt;
        if (cnt == '1) begin
          state_next = xpsc_pkg::ST_SH_RD1;
        end
      end
      xpsc_pkg::ST_SH_RD1: begin
        prng_cmd.gen = 1'b1;
        if (gen_word[7:0] != gen_word[15:8]) begin
          tbl_rd0.re   = 1'b1;
          tbl_rd0.addr = gen_word[7:0];
          tbl_rd1.re   = 1'b1;
          tbl_rd1.addr = gen_word[15:8];
          state_next   = xpsc_pkg::ST_SH_RD2;
        end else begin
          // equal bytes: drop the round
          round_end = 1'b1;
          if (round_cnt == RND_LAST) begin
            state_next = xpsc_pkg::ST_KEY;
          end
        end
      end
      xpsc_pkg::ST_SH_RD2: begin
        tbl_rd0.re   = 1'b1;
        tbl_rd0.addr = rdata0;
        tbl_rd1.re   = 1'b1;
        tbl_rd1.addr = rdata1;
        state_next   = xpsc_pkg::ST_SH_W1;
      end
      xpsc_pkg::ST_SH_W1: begin
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = swap_a;
        tbl_wr.data = rdata1;
        state_next  = xpsc_pkg::ST_SH_W2;
      end
      xpsc_pkg::ST_SH_W2: begin
        tbl_wr.we   = 1'b1;
        tbl_wr.addr = swap_b;
        tbl_wr.data = swap_ta;
        round_end   = 1'b1;
        state_next  = (round_cnt == RND_LAST) ? xpsc_pkg::ST_KEY : xpsc_pkg::ST_SH_RD1;
      end
      xpsc_pkg::ST_KEY: begin
        tbl_rd0.re = 1'b1;
        if (position[xpsc_pkg::BYTE_W-1:0] == '0) begin
          // block boundary: fetch the prime index first
          tbl_rd0.addr = position[xpsc_pkg::POS_W-1:xpsc_pkg::BYTE_W];
          state_next   = xpsc_pkg::ST_KEY_WAIT;
        end else begin
          tbl_rd0.addr = ks_idx;
          state_next   = xpsc_pkg::ST_KS_WAIT;
        end
      end
      xpsc_pkg::ST_KEY_WAIT: begin
        state_next = xpsc_pkg::ST_IDX;
      end
      xpsc_pkg::ST_IDX: begin
        tbl_rd0.re   = 1'b1;
        tbl_rd0.addr = ks_idx;
        state_next   = xpsc_pkg::ST_KS_WAIT;
      end
      xpsc_pkg::ST_KS_WAIT: begin
        // read data holds while the output register is full
        if (!out_valid || out_stream.ready) begin
          out_load   = 1'b1;
          state_next = xpsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = xpsc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_seed <= '0;
    end else if (cfg_we) begin
      key_seed <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_data  <= in_stream.data_in;
      hold_last  <= in_stream.last;
    end
  end

  // position and prime key
  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      prime_key <= '0;
    end else begin
      if (in_take && in_stream.first) begin
        position <= '0;
      end else if (out_load) begin
        position <= pos_inc;
      end
      if (state == xpsc_pkg::ST_KEY_WAIT) begin
        prime_key <= xpsc_pkg::BYTE_W'(xpsc_pkg::PRIMES[rdata0]);
      end
    end
  end

  // build counters and swap holding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      round_cnt <= '0;
    end else begin
      if (in_take) begin
        cnt <= (key_seed != '0) ? xpsc_pkg::TBL_AW'(1) : '0;
      end else if (state == xpsc_pkg::ST_SEED) begin
        cnt <= (cnt[1:0] == 2'd3) ? '0 : cnt + 1'b1;
      end else if (state == xpsc_pkg::ST_FILL) begin
        cnt <= cnt + 1'b1;
      end
      if (state == xpsc_pkg::ST_FILL) begin
        round_cnt <= '0;
      end else if (round_end) begin
        round_cnt <= round_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == xpsc_pkg::ST_SH_RD2) begin
      swap_a <= rdata0;
      swap_b <= rdata1;
    end
    if (state == xpsc_pkg::ST_SH_W1) begin
      swap_ta <= rdata0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= hold_data ^ rdata0;
      out_last <= hold_last;
    end
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_xorshift_permutation_stream_cipher_top.sv
`default_nettype none

module tb_xorshift_permutation_stream_cipher_top;

  // Run limit in cycles. Take the slowest correct run. Random messages average
  // near 100 words, so about 1200 words start some 20 messages, each with a
  // table build; the builds make up most of the run, and the words, gaps and
  // stalls add little. The limit takes the slowest run several times over.
  localparam int unsigned RUN_LIMIT = 5_000_000;

  typedef struct packed {
    logic                        first;
    logic [xpsc_pkg::BYTE_W-1:0] data;
    logic                        last;
  } cipher_word_t;

  typedef struct packed {
    logic [xpsc_pkg::BYTE_W-1:0] data_out;
    logic                        last_res;
  } cipher_result_t;

  logic                        clk;
  logic                        rst;
  logic                        cfg_we;
  logic [xpsc_pkg::WORD_W-1:0] cfg_wdata;

  xpsc_in_if  in_if ();
  xpsc_out_if out_if ();

  xorshift_permutation_stream_cipher_top uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_stream  (in_if),
    .out_stream (out_if)
  );

  // Queued words waiting for the driver, and cipher results still owed by the DUT.
  cipher_word_t   tx_words[$];
  cipher_result_t cipher_due[$];

  int unsigned queued_total;
  int unsigned accepted_total = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned src_gap;
  int unsigned sink_stall;
  logic        idle_on;

  // Shadow of the cipher state: seed register, permutation table, generator,
  // position in the message and current prime multiplier.
  logic [xpsc_pkg::WORD_W-1:0] seed_shadow;
  logic [7:0]        perm_tbl [256];
  logic [31:0]       gen_w [4];
  logic [15:0]       msg_pos = 16'd0;
  logic [7:0]        prime_mult = 8'd0;
  logic [7:0]        prime_lsb [256];

  // Low bytes of the first 256 odd primes, found by trial division.
  function automatic void find_prime_lsbs();
    int unsigned found;
    int unsigned cand;
    int unsigned d;
    logic        is_p;
    found = 0;
    cand  = 3;
    while (found < 256) begin
      is_p = 1'b1;
      for (d = 3; d * d <= cand; d += 2) begin
        if (cand % d == 0) begin
          is_p = 1'b0;
          break;
        end
      end
      if (is_p) begin
        prime_lsb[found] = cand[7:0];
        found++;
      end
      cand += 2;
    end
  endfunction

  // Step the xorshift128 generator one word.
  function automatic logic [31:0] next_gen_word();
    logic [31:0] x;
    logic [31:0] y;
    x = gen_w[0];
    y = gen_w[3];
    gen_w[0] = gen_w[1];
    gen_w[1] = gen_w[2];
    gen_w[2] = gen_w[3];
    x = x ^ (x << 11);
    x = x ^ (x >> 8);
    gen_w[3] = x ^ y ^ (y >> 19);
    return gen_w[3];
  endfunction

  // Seed the generator and shuffle the identity table.
  function automatic void rebuild_perm(input logic [31:0] seed);
    logic [31:0] s;
    logic [31:0] w;
    logic [7:0]  r1;
    logic [7:0]  r2;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  t;
    gen_w[0] = 32'h6C07_8966;
    gen_w[1] = 32'hDD52_54A5;
    gen_w[2] = 32'hB952_3B81;
    gen_w[3] = 32'h03DF_95B3;
    s = seed;
    if (s != 32'd0) begin
      for (int i = 1; i <= 3; i++) begin
        s = s ^ (s >> 30);
        s = s * 32'h6C07_8965 + 32'(i);
        gen_w[i-1] = s;
      end
    end
    for (int i = 0; i < 256; i++) perm_tbl[i] = 8'(i);
    for (int i = 0; i < 4096; i++) begin
      w  = next_gen_word();
      r1 = w[7:0];
      r2 = w[15:8];
      if (r1 != r2) begin
        a = perm_tbl[r1];
        b = perm_tbl[r2];
        t = perm_tbl[a];
        perm_tbl[a] = perm_tbl[b];
        perm_tbl[b] = t;
      end
    end
  endfunction

  // Work out the cipher result for one accepted word and advance the shadow state.
  function automatic cipher_result_t cipher_predict(input cipher_word_t w);
    cipher_result_t r;
    logic [23:0]    prod;
    logic [7:0]     ks;
    if (w.first) begin
      rebuild_perm(seed_shadow);
      msg_pos = 16'd0;
    end
    // reload the prime at each 256-word block boundary, wrap included
    if (msg_pos[7:0] == 8'd0) prime_mult = prime_lsb[perm_tbl[msg_pos[15:8]]];
    prod = prime_mult * ({1'b0, msg_pos} + 17'd1);
    ks = perm_tbl[prod[7:0]];
    r.data_out = w.data ^ ks;
    r.last_res = w.last;
    msg_pos = msg_pos + 16'd1;
    return r;
  endfunction

  task automatic queue_word(input logic first, input logic [7:0] data, input logic last);
    cipher_word_t w;
    w.first = first;
    w.data  = data;
    w.last  = last;
    tx_words = {tx_words, w};
    queued_total++;
  endtask

  // Hold until every queued word is accepted and every result has been checked.
  task automatic wait_drained();
    do @(posedge clk);
    while (!(accepted_total == queued_total && cipher_due.size() == 0));
  endtask

  // Write the seed register while the block is idle, then mirror it.
  task automatic load_seed(input logic [xpsc_pkg::WORD_W-1:0] v);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_shadow = v;
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: present queued words on in_if, with random gap bursts while idling is on.
  always @(posedge clk) begin
    cipher_word_t   nxt;
    cipher_result_t exp_r;
    if (rst) begin
      in_if.valid   <= 1'b0;
      in_if.first   <= 1'b0;
      in_if.data_in <= 8'd0;
      in_if.last    <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        nxt.first = in_if.first;
        nxt.data  = in_if.data_in;
        nxt.last  = in_if.last;
        exp_r = cipher_predict(nxt);
        cipher_due = {cipher_due, exp_r};
        accepted_total++;
      end
      // advance only when nothing is held or the held word just went through
      if (!in_if.valid || in_if.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_if.valid <= 1'b0;
        end else if (idle_on && tx_words.size() != 0 && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(1, 15) - 1;
          in_if.valid <= 1'b0;
        end else if (tx_words.size() != 0) begin
          nxt = tx_words.pop_front();
          in_if.valid   <= 1'b1;
          in_if.first   <= nxt.first;
          in_if.data_in <= nxt.data;
          in_if.last    <= nxt.last;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction, stall at random.
  always @(posedge clk) begin
    cipher_result_t want;
    if (rst) begin
      out_if.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (cipher_due.size() == 0) begin
          $error("result word with nothing pending: data_out=%02h last_res=%0b",
                 out_if.data_out, out_if.last_res);
          mismatch_count++;
        end else begin
          want = cipher_due.pop_front();
          if (out_if.data_out !== want.data_out) begin
            $error("data_out expected %02h actual %02h", want.data_out, out_if.data_out);
            mismatch_count++;
          end
          if (out_if.last_res !== want.last_res) begin
            $error("last_res expected %0b actual %0b", want.last_res, out_if.last_res);
            mismatch_count++;
          end
        end
      end
      if (sink_stall > 0) begin
        sink_stall--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        sink_stall = $urandom_range(1, 15) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: drop the run if it goes far past the slowest correct one.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL xorshift_permutation_stream_cipher_top");
      $finish;
    end
  end

  // Stimulus: directed words first, then random messages over several seeds;
  // the last phases run without idling.
  initial begin
    int unsigned msg_left;
    logic        start;
    logic        lst;
    logic [7:0]  d;
    logic [31:0] sd;

    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    idle_on        = 1'b1;
    queued_total   = 0;
    msg_left       = 0;
    seed_shadow    = '0;
    find_prime_lsbs();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Zero seed straight out of reset: the generator keeps its fixed words.
    // The very first word starts a message, so the table is never read unbuilt.
    queue_word(1'b1, 8'h00, 1'b0);
    queue_word(1'b0, 8'hFF, 1'b0);
    queue_word(1'b0, 8'h55, 1'b0);
    queue_word(1'b0, 8'hAA, 1'b1);
    // single-word message: first and last together
    queue_word(1'b1, 8'h80, 1'b1);
    wait_drained();

    // Largest seed.
    load_seed(32'hFFFF_FFFF);
    queue_word(1'b1, 8'hFF, 1'b0);
    queue_word(1'b0, 8'h00, 1'b0);
    queue_word(1'b0, 8'h01, 1'b0);
    queue_word(1'b0, 8'hFE, 1'b0);
    queue_word(1'b0, 8'h7F, 1'b1);
    wait_drained();

    // Smallest nonzero seed, then a seed change mid-message: the running
    // message keeps its table and only the next first word picks up the seed.
    load_seed(32'h0000_0001);
    queue_word(1'b1, 8'h12, 1'b0);
    queue_word(1'b0, 8'h34, 1'b0);
    queue_word(1'b0, 8'h56, 1'b0);
    queue_word(1'b0, 8'h78, 1'b0);
    wait_drained();
    load_seed(32'h8000_0000);
    queue_word(1'b0, 8'h9A, 1'b0);
    queue_word(1'b0, 8'hBC, 1'b1);
    queue_word(1'b1, 8'hDE, 1'b0);
    queue_word(1'b0, 8'hF0, 1'b1);
    wait_drained();

    // Random messages. Most are short, some are long enough to cross 256-word
    // block boundaries. Rarely restart a message mid-way. Messages run across
    // seed writes; one middle phase and the last two go without idling.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: sd = 32'h0000_0000;
        1: sd = 32'hFFFF_FFFF;
        default: begin
          case ($urandom_range(0, 3))
            0: sd = 32'h0000_0000;
            1: sd = 32'h1 << $urandom_range(0, 31);
            default: sd = $urandom();
          endcase
        end
      endcase
      load_seed(sd);
      idle_on = (ph != 3) && (ph < 6);
      for (int n = 0; n < 150; n++) begin
        if (msg_left == 0) begin
          msg_left = ($urandom_range(0, 4) == 0) ? $urandom_range(200, 500)
                                                 : $urandom_range(1, 64);
          start = 1'b1;
        end else begin
          start = ($urandom_range(0, 199) == 0);
        end
        msg_left--;
        lst = (msg_left == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        case ($urandom_range(0, 7))
          0: d = 8'h00;
          1: d = 8'hFF;
          default: d = 8'($urandom_range(0, 255));
        endcase
        queue_word(start, d, lst);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && cipher_due.size() == 0) begin
      $display("PASS xorshift_permutation_stream_cipher_top");
    end else begin
      $display("FAIL xorshift_permutation_stream_cipher_top");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
rtl/core/xpsc_pkg.sv
rtl/core/xpsc_in_if.sv
rtl/core/xpsc_out_if.sv
rtl/core/xpsc_table_ram.sv
rtl/core/xpsc_prng.sv
rtl/core/xorshift_permutation_stream_cipher_top.sv
tb/sv/tb_xorshift_permutation_stream_cipher_top.sv
